// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the heavy-hitter table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define WHHT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define WHHT_NEVER(lbl, clk, rst_n, cond, msg) \
    `WHHT_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== hw/rtl/whht_pkg.sv =====
// ----------------------------------------------------------------------------
// whht_pkg
// Types, codes and helpers shared by the weighted heavy-hitter table.
// ----------------------------------------------------------------------------
package whht_pkg;

    localparam int FILE_W  = 32;
    localparam int LINE_W  = 20;
    localparam int WGT_W   = 32;
    localparam int CNT_W   = 48;
    localparam int SLOT_W  = 3;
    localparam int OUTC_W  = 3;

    // Outcome codes of one result beat
    localparam logic [OUTC_W-1:0] OUTC_MATCHED  = 3'd0;
    localparam logic [OUTC_W-1:0] OUTC_EMPTY    = 3'd1;
    localparam logic [OUTC_W-1:0] OUTC_REPLACED = 3'd2;
    localparam logic [OUTC_W-1:0] OUTC_DISCARD  = 3'd3;
    localparam logic [OUTC_W-1:0] OUTC_READ     = 3'd4;

    // Function codes of an input beat
    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef struct packed {
        logic              func;
        logic [FILE_W-1:0] site_file;
        logic [LINE_W-1:0] site_line;
        logic [WGT_W-1:0]  weight;
        logic [SLOT_W-1:0] read_slot;
    } t_in_item;

    typedef struct packed {
        logic [OUTC_W-1:0] outcome;
        logic [SLOT_W-1:0] slot;
        logic              entry_valid;
        logic [FILE_W-1:0] entry_file;
        logic [LINE_W-1:0] entry_line;
        logic [CNT_W-1:0]  entry_total;
        logic [CNT_W-1:0]  entry_counter;
        logic [CNT_W-1:0]  grand_total;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // load the input beat into the work register
        logic commit;   // update the table and load the result register
    } t_dp_cmd;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_ctrl_state;

    // 48-bit add that sticks at all ones
    function automatic logic [CNT_W-1:0] sat_add48(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/whht_ctrl.sv =====
// ----------------------------------------------------------------------------
// whht_ctrl
// Controller: sequences capture and commit, and owns the result valid flag.
// ----------------------------------------------------------------------------
module whht_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output whht_pkg::t_dp_cmd o_cmd
);

`include "assert_macros.svh"

    whht_pkg::t_ctrl_state r_state, n_state;
    logic                  r_out_valid, n_out_valid;
    logic                  out_free;

    // Result register can take a new beat this cycle
    assign out_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            whht_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = whht_pkg::ST_EXEC;
            end
            whht_pkg::ST_EXEC: begin
                if (out_free) n_state = whht_pkg::ST_IDLE;
            end
            default: n_state = whht_pkg::ST_IDLE;
        endcase
    end

    // Outputs and commands
    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            whht_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            whht_pkg::ST_EXEC: begin
                o_cmd.commit = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Result valid: set on commit, drop when the beat is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit)                  n_out_valid = 1'b1;
        else if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= whht_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `WHHT_NEVER(a_cap_commit_excl, i_clk, i_rst_n, o_cmd.capture && o_cmd.commit, "capture and commit together")
    `WHHT_ASSERT(a_commit_shows, i_clk, i_rst_n, o_cmd.commit |=> r_out_valid, "commit without result")
    `WHHT_ASSERT(a_exec_waits, i_clk, i_rst_n, (r_state == whht_pkg::ST_EXEC && r_out_valid && !i_out_ready) |=> (r_state == whht_pkg::ST_EXEC), "left exec while result stalled")

endmodule

// ===== hw/rtl/whht_dp.sv =====
// ----------------------------------------------------------------------------
// whht_dp
// Datapath: slot table, parallel match/decay/replace update, result register.
// ----------------------------------------------------------------------------
module whht_dp #(
    parameter int SLOTS = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  whht_pkg::t_dp_cmd    i_cmd,
    input  whht_pkg::t_in_item   i_in_data,
    output whht_pkg::t_out_item  o_out_data
);

`include "assert_macros.svh"

    localparam int IW = $clog2(SLOTS);
    localparam int CW = whht_pkg::CNT_W;

    whht_pkg::t_in_item  r_in;
    whht_pkg::t_out_item r_out, n_out;

    logic [SLOTS-1:0]                r_valid, n_valid;
    logic [whht_pkg::FILE_W-1:0]     r_file    [SLOTS];
    logic [whht_pkg::FILE_W-1:0]     n_file    [SLOTS];
    logic [whht_pkg::LINE_W-1:0]     r_line    [SLOTS];
    logic [whht_pkg::LINE_W-1:0]     n_line    [SLOTS];
    logic [CW-1:0]                   r_total   [SLOTS];
    logic [CW-1:0]                   n_total   [SLOTS];
    logic [CW-1:0]                   r_counter [SLOTS];
    logic [CW-1:0]                   n_counter [SLOTS];
    logic [CW-1:0]                   r_wsum, n_wsum;

    logic [SLOTS-1:0] hit, drop;
    logic [CW-1:0]    w48;

    assign w48 = CW'(r_in.weight);

    // Per-slot compare: site match and decay drop
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            hit[i]  = r_valid[i] && (r_file[i] == r_in.site_file)
                      && (r_line[i] == r_in.site_line);
            drop[i] = (r_counter[i] <= w48);
        end
    end

    // Table update and result selection
    always_comb begin
        logic [IW-1:0] m_idx, e_idx, d_idx, idx;
        logic          any_m, any_e, any_d, have;
        logic [whht_pkg::OUTC_W-1:0] outc;

        n_valid   = r_valid;
        n_file    = r_file;
        n_line    = r_line;
        n_total   = r_total;
        n_counter = r_counter;
        n_wsum    = r_wsum;

        // Lowest match, lowest empty, highest drop
        any_m = 1'b0;
        m_idx = '0;
        any_e = 1'b0;
        e_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (hit[i]) begin
                any_m = 1'b1;
                m_idx = IW'(i);
            end
            if (!r_valid[i]) begin
                any_e = 1'b1;
                e_idx = IW'(i);
            end
        end
        any_d = 1'b0;
        d_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (drop[i]) begin
                any_d = 1'b1;
                d_idx = IW'(i);
            end
        end

        idx  = IW'(r_in.read_slot);
        have = (32'(r_in.read_slot) < SLOTS);
        outc = whht_pkg::OUTC_READ;

        if (r_in.func == whht_pkg::FUNC_ADD) begin
            n_wsum = whht_pkg::sat_add48(r_wsum, w48);
            have   = 1'b1;
            if (any_m) begin
                n_total[m_idx]   = whht_pkg::sat_add48(r_total[m_idx], w48);
                n_counter[m_idx] = whht_pkg::sat_add48(r_counter[m_idx], w48);
                idx  = m_idx;
                outc = whht_pkg::OUTC_MATCHED;
            end else if (any_e) begin
                n_valid[e_idx]   = 1'b1;
                n_file[e_idx]    = r_in.site_file;
                n_line[e_idx]    = r_in.site_line;
                n_total[e_idx]   = w48;
                n_counter[e_idx] = w48;
                idx  = e_idx;
                outc = whht_pkg::OUTC_EMPTY;
            end else begin
                // Table full: decay every counter, clear what runs out
                for (int i = 0; i < SLOTS; i++) begin
                    if (drop[i]) begin
                        n_valid[i]   = 1'b0;
                        n_file[i]    = '0;
                        n_line[i]    = '0;
                        n_total[i]   = '0;
                        n_counter[i] = '0;
                    end else begin
                        n_counter[i] = r_counter[i] - w48;
                    end
                end
                if (any_d) begin
                    n_valid[d_idx]   = 1'b1;
                    n_file[d_idx]    = r_in.site_file;
                    n_line[d_idx]    = r_in.site_line;
                    n_total[d_idx]   = w48;
                    n_counter[d_idx] = w48;
                    idx  = d_idx;
                    outc = whht_pkg::OUTC_REPLACED;
                end else begin
                    have = 1'b0;
                    idx  = '0;
                    outc = whht_pkg::OUTC_DISCARD;
                end
            end
        end

        n_out.outcome     = outc;
        n_out.slot        = (r_in.func == whht_pkg::FUNC_READ) ? r_in.read_slot
                                                               : whht_pkg::SLOT_W'(idx);
        n_out.grand_total = n_wsum;
        if (have) begin
            n_out.entry_valid   = n_valid[idx];
            n_out.entry_file    = n_file[idx];
            n_out.entry_line    = n_line[idx];
            n_out.entry_total   = n_total[idx];
            n_out.entry_counter = n_counter[idx];
        end else begin
            n_out.entry_valid   = 1'b0;
            n_out.entry_file    = '0;
            n_out.entry_line    = '0;
            n_out.entry_total   = '0;
            n_out.entry_counter = '0;
        end
    end

    // Hold the input beat for the execute cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_in <= i_in_data;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) r_out <= n_out;
    end

    // Table state: cleared at reset, written on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_wsum  <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_file[i]    <= '0;
                r_line[i]    <= '0;
                r_total[i]   <= '0;
                r_counter[i] <= '0;
            end
        end else if (i_cmd.commit) begin
            r_valid   <= n_valid;
            r_wsum    <= n_wsum;
            r_file    <= n_file;
            r_line    <= n_line;
            r_total   <= n_total;
            r_counter <= n_counter;
        end
    end

    assign o_out_data = r_out;

    `WHHT_ASSERT(a_read_no_change, i_clk, i_rst_n, (i_cmd.commit && r_in.func == whht_pkg::FUNC_READ) |=> ($stable(r_valid) && $stable(r_wsum)), "read changed the table")
    `WHHT_ASSERT(a_wsum_monotonic, i_clk, i_rst_n, i_cmd.commit |=> (r_wsum >= $past(r_wsum)), "grand total went down")

endmodule

// ===== hw/rtl/weighted_heavy_hitter_table_core.sv =====
// ----------------------------------------------------------------------------
// weighted_heavy_hitter_table_core
// Weighted heavy-hitter table of allocation sites with decay and replacement.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid/o_in_ready  | i_in_data  (whht_pkg::t_in_item)
//  out     | output    | o_out_valid/i_out_ready| o_out_data (whht_pkg::t_out_item)
//
//  Each beat is first captured, then used in the parallel update of all
//  SLOTS entries (match, decay and replace compares), which loads the result.
//  A new input beat is taken while the previous result still waits.
//  A stalled result holds the update cycle until the result register frees.
//  Synchronous active-low reset clears the table and the grand total.
// ----------------------------------------------------------------------------
module weighted_heavy_hitter_table_core #(
    parameter int SLOTS = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  whht_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output whht_pkg::t_out_item o_out_data
);

    whht_pkg::t_dp_cmd cmd;

    // Sequencing
    whht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // Table and result
    whht_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the weighted heavy-hitter table core. A site table
// tracker mirrors the slot table and grand total, predicts one report per
// accepted input beat and checks each output beat in order. Directed beats
// cover empty reads, out-of-range reads, fill, match, decay with discard and
// with replacement. Random beats draw mostly from a small site pool, with
// full-scale weights now and then. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

class site_table_tracker;
    localparam int N_SLOTS  = 5;
    localparam int SHOW_MAX = 10;
    localparam int CW       = whht_pkg::CNT_W;

    logic                         tab_vld   [N_SLOTS];
    logic [whht_pkg::FILE_W-1:0]  tab_file  [N_SLOTS];
    logic [whht_pkg::LINE_W-1:0]  tab_line  [N_SLOTS];
    logic [whht_pkg::CNT_W-1:0]   tab_total [N_SLOTS];
    logic [whht_pkg::CNT_W-1:0]   tab_cnt   [N_SLOTS];
    logic [whht_pkg::CNT_W-1:0]   byte_sum;

    whht_pkg::t_out_item pending_reports [$];
    int mismatches;

    function new();
        for (int i = 0; i < N_SLOTS; i++) begin
            wipe_slot(i);
        end
        byte_sum   = '0;
        mismatches = 0;
    endfunction

    function void wipe_slot(int i);
        tab_vld[i]   = 1'b0;
        tab_file[i]  = '0;
        tab_line[i]  = '0;
        tab_total[i] = '0;
        tab_cnt[i]   = '0;
    endfunction

    // Add and stick at all ones
    function logic [whht_pkg::CNT_W-1:0] clamp_add(logic [whht_pkg::CNT_W-1:0] a,
                                                  logic [whht_pkg::CNT_W-1:0] b);
        logic [whht_pkg::CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[whht_pkg::CNT_W] ? {whht_pkg::CNT_W{1'b1}} : s[whht_pkg::CNT_W-1:0];
    endfunction

    // Build a report that shows the stored contents of one slot
    function whht_pkg::t_out_item slot_report(logic [whht_pkg::OUTC_W-1:0] outc, int idx);
        whht_pkg::t_out_item r;
        r               = '0;
        r.outcome       = outc;
        r.slot          = idx[whht_pkg::SLOT_W-1:0];
        r.entry_valid   = tab_vld[idx];
        r.entry_file    = tab_file[idx];
        r.entry_line    = tab_line[idx];
        r.entry_total   = tab_total[idx];
        r.entry_counter = tab_cnt[idx];
        r.grand_total   = byte_sum;
        return r;
    endfunction

    function void claim_slot(int i, whht_pkg::t_in_item it, logic [whht_pkg::CNT_W-1:0] w);
        tab_vld[i]   = 1'b1;
        tab_file[i]  = it.site_file;
        tab_line[i]  = it.site_line;
        tab_total[i] = w;
        tab_cnt[i]   = w;
    endfunction

    // Advance the table by one accepted input beat and queue its report
    function void predict_beat(whht_pkg::t_in_item it);
        whht_pkg::t_out_item          r;
        logic [whht_pkg::CNT_W-1:0]   w;
        int                           hit;
        int                           spare;
        int                           pick;
        r     = '0;
        w     = {{(whht_pkg::CNT_W-whht_pkg::WGT_W){1'b0}}, it.weight};
        hit   = -1;
        spare = -1;
        pick  = -1;
        if (it.func == whht_pkg::FUNC_READ) begin
            if (it.read_slot < N_SLOTS) begin
                r = slot_report(whht_pkg::OUTC_READ, int'(it.read_slot));
            end else begin
                // out-of-range read reports only the index and the grand total
                r.outcome     = whht_pkg::OUTC_READ;
                r.slot        = it.read_slot;
                r.grand_total = byte_sum;
            end
        end else begin
            byte_sum = clamp_add(byte_sum, w);
            for (int i = 0; i < N_SLOTS; i++) begin
                if (hit < 0 && tab_vld[i] && tab_file[i] == it.site_file &&
                    tab_line[i] == it.site_line) begin
                    hit = i;
                end
                if (spare < 0 && !tab_vld[i]) begin
                    spare = i;
                end
            end
            if (hit >= 0) begin
                tab_total[hit] = clamp_add(tab_total[hit], w);
                tab_cnt[hit]   = clamp_add(tab_cnt[hit], w);
                r = slot_report(whht_pkg::OUTC_MATCHED, hit);
            end else if (spare >= 0) begin
                claim_slot(spare, it, w);
                r = slot_report(whht_pkg::OUTC_EMPTY, spare);
            end else begin
                // table full: decay every counter, drop those at or below weight
                for (int i = 0; i < N_SLOTS; i++) begin
                    if (tab_cnt[i] <= w) begin
                        wipe_slot(i);
                        pick = i;
                    end else begin
                        tab_cnt[i] = tab_cnt[i] - w;
                    end
                end
                if (pick >= 0) begin
                    claim_slot(pick, it, w);
                    r = slot_report(whht_pkg::OUTC_REPLACED, pick);
                end else begin
                    r.outcome     = whht_pkg::OUTC_DISCARD;
                    r.grand_total = byte_sum;
                end
            end
        end
        pending_reports.push_back(r);
    endfunction

    function void flag(string msg);
        mismatches++;
        if (mismatches <= SHOW_MAX) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endfunction

    function void cmp_field(string name, logic [whht_pkg::CNT_W-1:0] want,
                            logic [whht_pkg::CNT_W-1:0] got);
        if (got !== want) begin
            flag($sformatf("mismatch on %s: expected %h, got %h", name, want, got));
        end
    endfunction

    // Check one output beat against the oldest queued report
    function void check_out_beat(whht_pkg::t_out_item got);
        whht_pkg::t_out_item want;
        if (pending_reports.size() == 0) begin
            flag($sformatf("output beat with no report pending: %h", got));
            return;
        end
        want = pending_reports.pop_front();
        cmp_field("outcome",       CW'(want.outcome),     CW'(got.outcome));
        cmp_field("slot",          CW'(want.slot),        CW'(got.slot));
        cmp_field("entry_valid",   CW'(want.entry_valid), CW'(got.entry_valid));
        cmp_field("entry_file",    CW'(want.entry_file),  CW'(got.entry_file));
        cmp_field("entry_line",    CW'(want.entry_line),  CW'(got.entry_line));
        cmp_field("entry_total",   want.entry_total,      got.entry_total);
        cmp_field("entry_counter", want.entry_counter,    got.entry_counter);
        cmp_field("grand_total",   want.grand_total,      got.grand_total);
    endfunction

    function int pending_count();
        return pending_reports.size();
    endfunction
endclass

module tb_top;

    localparam int IDLE_LIMIT  = 4000;
    localparam int RAND_BEATS  = 610;
    localparam int POOL_SITES  = 10;
    localparam int SW          = whht_pkg::SLOT_W;
    localparam int LW          = whht_pkg::LINE_W;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    whht_pkg::t_in_item  i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    whht_pkg::t_out_item o_out_data;

    site_table_tracker tracker = new();

    logic [whht_pkg::FILE_W-1:0] pool_file [POOL_SITES];
    logic [whht_pkg::LINE_W-1:0] pool_line [POOL_SITES];
    bit                          in_quiet  = 1'b0;
    bit                          out_quiet = 1'b0;
    int                          stall_left = 0;

    weighted_heavy_hitter_table_core #(
        .SLOTS (5)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic whht_pkg::t_in_item add_beat(logic [whht_pkg::FILE_W-1:0] f,
                                                    logic [whht_pkg::LINE_W-1:0] l,
                                                    logic [whht_pkg::WGT_W-1:0]  w);
        whht_pkg::t_in_item it;
        it.func      = whht_pkg::FUNC_ADD;
        it.site_file = f;
        it.site_line = l;
        it.weight    = w;
        it.read_slot = SW'($urandom);
        return it;
    endfunction

    function automatic whht_pkg::t_in_item read_beat(logic [whht_pkg::SLOT_W-1:0] s);
        whht_pkg::t_in_item it;
        it.func      = whht_pkg::FUNC_READ;
        it.site_file = $urandom;
        it.site_line = LW'($urandom);
        it.weight    = $urandom;
        it.read_slot = s;
        return it;
    endfunction

    // Mostly pooled sites so matches and decay happen, some fresh sites
    function automatic whht_pkg::t_in_item random_beat();
        whht_pkg::t_in_item          it;
        int                          r;
        int                          p;
        logic [whht_pkg::WGT_W-1:0]  w;
        r = $urandom_range(0, 99);
        if (r < 20) return read_beat(SW'($urandom_range(0, 7)));
        r = $urandom_range(0, 99);
        if (r < 30)      w = $urandom_range(0, 255);
        else if (r < 55) w = $urandom_range(0, 4095);
        else if (r < 70) w = $urandom_range(0, 65535);
        else if (r < 88) w = $urandom;
        else if (r < 94) w = '0;
        else             w = '1;
        if ($urandom_range(0, 99) < 85) begin
            p  = $urandom_range(0, POOL_SITES - 1);
            it = add_beat(pool_file[p], pool_line[p], w);
        end else begin
            it = add_beat($urandom, LW'($urandom), w);
        end
        return it;
    endfunction

    // Present one input beat and hold it until accepted
    task automatic send_item(input whht_pkg::t_in_item it);
        int gap;
        gap = pick_gap(in_quiet);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.predict_beat(it);
    endtask

    // Check output beats and stall the result side at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tracker.check_out_beat(o_out_data);
        end
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else begin
            stall_left  <= pick_gap(out_quiet);
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog: end the run when neither channel moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        int k;
        for (k = 0; k < POOL_SITES; k++) begin
            pool_file[k] = $urandom;
            pool_line[k] = LW'($urandom);
        end
        pool_file[0] = '0;
        pool_line[0] = '0;
        pool_file[1] = '1;
        pool_line[1] = '1;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, in-range and out-of-range reads
        send_item(read_beat(3'd0));
        send_item(read_beat(3'd5));
        send_item(read_beat(3'd7));
        // fill: zero site with zero weight, all-ones site with full weight
        send_item(add_beat('0, '0, '0));
        send_item(add_beat('1, '1, '1));
        send_item(add_beat('0, '0, 32'd100));
        send_item(add_beat(32'h0000_0c00, 20'd50, 32'd50));
        send_item(add_beat(32'h0000_0d00, 20'd20, 32'd20));
        send_item(add_beat(32'h0000_0e00, 20'd10, 32'd10));
        // full table, every counter above weight: discard
        send_item(add_beat(32'h0000_0f00, 20'd5, 32'd5));
        for (k = 0; k < 5; k++) send_item(read_beat(k[2:0]));
        // two entries drop, the higher one is reused
        send_item(add_beat(32'h0000_1000, 20'd15, 32'd15));
        send_item(read_beat(3'd3));
        send_item(read_beat(3'd4));
        // dropped slot taken as empty, then zero weight drops a zero counter
        send_item(add_beat(32'h0000_1100, 20'd1, 32'd0));
        send_item(add_beat(32'h0000_1200, 20'd2, 32'd0));
        send_item(add_beat('1, '1, '1));
        send_item(read_beat(3'd6));
        send_item(read_beat(3'd2));

        // random beats in stretches, some with no idling
        for (k = 0; k < RAND_BEATS; k++) begin
            if (k % 50 == 0) begin
                in_quiet  = ($urandom_range(0, 3) == 0);
                out_quiet = ($urandom_range(0, 3) == 0);
            end
            send_item(random_beat());
        end

        // read back every slot index, then a few more random beats
        in_quiet  = 1'b0;
        out_quiet = 1'b0;
        for (k = 0; k < 8; k++) send_item(read_beat(k[2:0]));
        for (k = 0; k < 12; k++) send_item(random_beat());

        i_in_valid <= 1'b0;
        while (tracker.pending_count() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (tracker.mismatches == 0 && tracker.pending_count() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
